// ----- rtl/layer_norm_column_core_assert.svh -----
// assertion macros for the column normalizer
`ifndef LAYER_NORM_COLUMN_CORE_ASSERT_SVH
`define LAYER_NORM_COLUMN_CORE_ASSERT_SVH

`define LNC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lnc assertion failed");

`define LNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lnc assertion failed");

`endif

// ----- rtl/lnc_pkg.sv -----
package lnc_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic signed [15:0] column_mean;
        logic [31:0]        column_variance;
        logic [15:0]        column_std;
        logic               last_out;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_VAR_RD,
        ST_VAR_ACC,
        ST_VAR_DIV,
        ST_SQRT,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mean_start;
        logic var_clear;
        logic var_rd;
        logic var_acc;
        logic vdiv_start;
        logic sqrt_start;
        logic out_rd;
        logic odiv_start;
        logic emit;
        logic col_done;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic rd_last;
        logic col_end;
    } t_status;

endpackage

// ----- rtl/lnc_div.sv -----
module lnc_div import lnc_pkg::*; #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_quot,
    output logic         o_done
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, n_quot;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem, r_quot[W-1]} - {1'b0, r_den};
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[W]) begin
                n_rem  = w_trial[W-1:0];
                n_quot = {r_quot[W-2:0], 1'b1};
            end else begin
                n_rem  = {r_rem[W-2:0], r_quot[W-1]};
                n_quot = {r_quot[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ----- rtl/lnc_sqrt.sv -----
module lnc_sqrt import lnc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_val,
    output logic [15:0] o_root,
    output logic        o_done
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [31:0] r_bit, n_bit;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_sum;

    always_comb begin
        w_sum  = {1'b0, r_root} + {1'b0, r_bit};
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_val;
            n_root = '0;
            n_bit  = 32'h4000_0000;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= w_sum) begin
                n_rem  = r_rem - w_sum[31:0];
                n_root = (r_root >> 1) + r_bit;
            end else begin
                n_root = r_root >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == 32'h1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
    end

    assign o_root = r_root[15:0];
    assign o_done = r_done;

endmodule

// ----- rtl/lnc_datapath.sv -----
module lnc_datapath import lnc_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in,
    output t_status   o_status,
    output t_out_beat o_out,
    output logic      o_valid
);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = 16 + CW;
    localparam int DW = 48;

    logic [15:0]        r_mem [MAX_LEN];
    logic [15:0]        r_rd_data;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_rd_addr;
    logic signed [SW-1:0] r_sum;
    logic signed [15:0] r_mean;
    logic [31:0]        r_var;
    logic [15:0]        r_std;
    logic [47:0]        r_sq;
    logic               r_neg;
    logic               r_rd_last;
    logic               r_last_tag;
    t_out_beat          r_out;
    logic               r_valid;

    logic [DW-1:0] w_div_num, w_div_den, w_quot;
    logic          w_div_start, w_div_done;
    logic [15:0]   w_root;
    logic          w_sqrt_done;
    logic [SW-1:0] w_abs_sum;
    logic signed [17:0] w_d;
    logic [35:0]   w_sqd;
    logic [17:0]   w_abs_d;
    logic [DW-1:0] w_scaled;
    logic [DW-1:0] w_q;

    assign w_abs_sum = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_d       = 18'(signed'(r_rd_data)) - 18'(r_mean);
    assign w_sqd     = 36'(w_d * w_d);
    assign w_abs_d   = w_d[17] ? 18'(-w_d) : 18'(w_d);
    assign w_scaled  = DW'({w_abs_d, 12'd0});

    always_comb begin
        w_div_start = i_cmd.mean_start | i_cmd.vdiv_start | i_cmd.odiv_start;
        w_div_num   = r_sq;
        w_div_den   = DW'(r_count);
        if (i_cmd.mean_start) begin
            w_div_num = DW'(w_abs_sum);
        end else if (i_cmd.odiv_start) begin
            w_div_num = w_scaled;
            w_div_den = DW'(r_std);
        end
    end

    lnc_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    lnc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (w_quot[31:0]),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    always_comb begin
        w_q = w_quot;
        if (r_std == 16'd0) begin
            w_q = '0;
        end else if (r_neg) begin
            w_q = (w_quot > DW'(32768)) ? DW'(32768) : w_quot;
            w_q = DW'(-w_q);
        end else if (w_quot > DW'(32767)) begin
            w_q = DW'(32767);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_count[AW-1:0]] <= i_in.sample;
        end
        if (i_cmd.var_rd || i_cmd.out_rd) begin
            r_rd_data  <= r_mem[r_rd_addr];
            r_rd_last  <= (CW'(r_rd_addr) == r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_var    <= '0;
            r_std    <= '0;
            r_valid  <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.load) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SW'(i_in.sample);
            end
            if (i_cmd.mean_start || i_cmd.var_clear) begin
                r_rd_addr <= '0;
            end
            if (i_cmd.var_clear) begin
                r_mean <= r_sum[SW-1] ? 16'(-w_quot) : w_quot[15:0];
            end
            if (i_cmd.var_rd || i_cmd.out_rd) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            if (i_cmd.vdiv_start) begin
                r_rd_addr <= '0;
            end
            if (i_cmd.sqrt_start) begin
                r_var <= w_quot[31:0];
            end
            if (w_sqrt_done) begin
                r_std <= w_root;
            end
            if (i_cmd.col_done) begin
                r_count <= '0;
                r_sum   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.var_clear) begin
            r_sq <= '0;
        end else if (i_cmd.var_acc) begin
            r_sq <= r_sq + 48'(w_sqd);
        end
        if (i_cmd.odiv_start) begin
            r_neg      <= w_d[17];
            r_last_tag <= r_rd_last;
        end
        if (i_cmd.emit) begin
            r_out.normalized      <= w_q[15:0];
            r_out.column_mean     <= r_mean;
            r_out.column_variance <= r_var;
            r_out.column_std      <= r_std;
            r_out.last_out        <= r_last_tag;
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.sqrt_done = w_sqrt_done;
    assign o_status.rd_last   = r_rd_last;
    assign o_status.col_end   = i_in.last || (r_count == CW'(MAX_LEN - 1));
    assign o_out   = r_out;
    assign o_valid = r_valid;

endmodule

// ----- rtl/lnc_ctrl.sv -----
module lnc_ctrl import lnc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
`include "layer_norm_column_core_assert.svh"

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_LOAD);
        case (r_state)
            ST_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.col_end) begin
                        n_state = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                o_cmd.mean_start = 1'b1;
                n_state = ST_VAR_DIV;
            end
            ST_VAR_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.var_clear = 1'b1;
                    n_state = ST_VAR_RD;
                end
            end
            ST_VAR_RD: begin
                o_cmd.var_rd = 1'b1;
                n_state = ST_VAR_ACC;
            end
            ST_VAR_ACC: begin
                o_cmd.var_acc = 1'b1;
                if (i_status.rd_last) begin
                    n_state = ST_SQRT;
                end else begin
                    o_cmd.var_rd = 1'b1;
                end
            end
            ST_SQRT: begin
                if (!i_status.sqrt_done) begin
                    o_cmd.vdiv_start = 1'b1;
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                if (i_status.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                end
                if (i_status.sqrt_done) begin
                    o_cmd.out_rd = 1'b1;
                    n_state = ST_OUT_DIV;
                end
            end
            ST_OUT_DIV: begin
                o_cmd.odiv_start = 1'b1;
                n_state = ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
                if (i_status.div_done) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.rd_last) begin
                        o_cmd.col_done = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.out_rd = 1'b1;
                        n_state = ST_OUT_DIV;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    `LNC_ASSERT_IMPL(a_load_only_idle, i_clk, i_rst_n, o_cmd.load, r_state == ST_LOAD)
    `LNC_ASSERT_NEXT(a_emit_then_idle, i_clk, i_rst_n, o_cmd.col_done, !o_busy)
    `LNC_ASSERT_IMPL(a_emit_on_done, i_clk, i_rst_n, o_cmd.emit, i_status.div_done)

endmodule

// ----- rtl/layer_norm_column_core.sv -----
// Column layer normalizer. Samples are taken one beat per cycle while busy is low;
// a beat with last set (or the MAX_LEN-th beat) ends the column and raises busy.
// The mean takes one serial divide, the variance one memory pass over the
// column and another serial divide, the root one serial square root, and
// each result one serial divide. Results leave one beat per o_valid pulse and
// the receiver cannot stall them; busy is already low in the cycle the final
// beat is on o_valid.
module layer_norm_column_core import lnc_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_in,
    output t_out_beat o_out,
    output logic      o_valid
);
    t_cmd    w_cmd;
    t_status w_status;

    lnc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    lnc_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in     (i_in),
        .o_status (w_status),
        .o_out    (o_out),
        .o_valid  (o_valid)
    );

endmodule
